// File: sv/sooeb_pkg.sv
// Shared types, constants and helpers for the stroke blend block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sooeb_pkg;

    // Fixed-point constants (16 fraction bits)
    localparam logic [17:0] ONE_Q16    = 18'd65536;
    localparam logic [17:0] MIN_ALPHA  = 18'd7;
    // floor(y / 255) == (y * DIV255_MUL) >> 33 for all 24-bit y
    localparam logic [25:0] DIV255_MUL = 26'd33686019;
    localparam logic [8:0]  OPACITY_MAX = 9'd256;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Divider: quotient bits and stages
    localparam int QBITS  = 9;
    localparam int BSTAGES = QBITS + 1;

    // Register indexes (paddr[2])
    localparam logic REG_OPACITY = 1'b0;
    localparam logic REG_ERASE   = 1'b1;

    typedef struct packed {
        logic [7:0] stroke_red;
        logic [7:0] stroke_green;
        logic [7:0] stroke_blue;
        logic [7:0] stroke_alpha;
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
    } pix_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       pixel_changed;
    } res_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [2:0][7:0]  base;
        logic             keep;
        logic             erase;
        logic [7:0]       alpha;
        logic [17:0]      oa;
        logic [2:0][25:0] num;
    } qent_t;

    // One divider stage
    typedef struct packed {
        logic [2:0][7:0]        base;
        logic                   keep;
        logic                   erase;
        logic [7:0]             alpha;
        logic [17:0]            oa;
        logic [2:0][26:0]       rem;
        logic [2:0][QBITS-1:0]  quo;
    } bst_t;

    function automatic logic [16:0] div255(input logic [23:0] y);
        logic [49:0] p;
        p = {26'd0, y} * {24'd0, DIV255_MUL};
        return p[49:33];
    endfunction

    function automatic logic [7:0] clamp8(input logic [10:0] v);
        return (v > 11'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/sooeb_front.sv
// Front end: accepts pixels, computes alphas and blend numerators, classifies.
// Depends on sooeb_pkg.
`default_nettype none
module sooeb_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [8:0]       opacity,
    input  wire logic             erase,
    input  wire logic             pix_valid,
    output logic                  pix_stall,
    input  wire sooeb_pkg::pix_t  pix,
    output logic                  push,
    input  wire logic             full,
    output sooeb_pkg::qent_t      qdata
);
    import sooeb_pkg::*;

    logic [5:1] v_reg, v_next;
    logic       en;

    pix_t        p1_reg, p2_reg, p3_reg, p4_reg;
    logic [15:0] x1_reg;
    logic [16:0] da1_reg, da2_reg;
    logic [16:0] sa2_reg, sa3_reg;
    logic        skip1_reg, skip2_reg, skip3_reg;
    logic        er1_reg, er2_reg, er3_reg;
    logic [33:0] prod3_reg;
    logic [2:0][24:0] ss3_reg, ss4_reg;
    logic [16:0] t4_reg;
    logic [17:0] oa4_reg;
    logic [7:0]  alpha4_reg;
    logic        keep4_reg, er4_reg;
    qent_t       q5_reg;

    // Stage combinational values
    logic [8:0]  op;
    logic [16:0] x_full;
    logic [16:0] ia;
    logic [33:0] trnd;
    logic [16:0] t;
    logic [17:0] oa;
    logic        keep;
    logic [42:0] ea_sum;
    logic [26:0] pa_sum;
    logic [7:0]  ea, pa;
    logic [2:0][7:0] srgb, drgb;
    logic [2:0][24:0] dt;

    // Pipeline advance
    assign en        = !v_reg[5] || !full;
    assign pix_stall = !en;
    assign push      = v_reg[5] && !full;
    assign qdata     = q5_reg;

    always_comb
    begin
        v_next = {v_reg[4:1], pix_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    // Stage 1: opacity scaling, base alpha to Q16
    always_comb
    begin
        op     = (opacity > OPACITY_MAX) ? OPACITY_MAX : opacity;
        x_full = {9'd0, pix.stroke_alpha} * {8'd0, op};
    end

    // Stage 3, 4 and 5 helpers
    always_comb
    begin
        ia     = 17'(ONE_Q16 - {1'b0, sa2_reg});
        trnd   = prod3_reg + 34'd32768;
        t      = trnd[32:16];
        oa     = {1'b0, sa3_reg} + {1'b0, t};
        keep   = skip3_reg || (!er3_reg && (oa < MIN_ALPHA));
        ea_sum = ({1'b0, prod3_reg, 8'd0} - {9'd0, prod3_reg}) + 43'h0080000000;
        ea     = clamp8(ea_sum[42:32]);
        pa_sum = ({1'b0, oa, 8'd0} - {9'd0, oa}) + 27'd32768;
        pa     = clamp8(pa_sum[26:16]);
        srgb   = {p2_reg.stroke_blue, p2_reg.stroke_green, p2_reg.stroke_red};
        drgb   = {p4_reg.base_blue, p4_reg.base_green, p4_reg.base_red};
        for (int i = 0; i < 3; i++)
            dt[i] = {17'd0, drgb[i]} * {8'd0, t4_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1
            p1_reg    <= pix;
            x1_reg    <= x_full[15:0];
            da1_reg   <= div255({pix.base_alpha, 16'd0} + 24'd127);
            skip1_reg <= (pix.stroke_alpha == 8'd0);
            er1_reg   <= erase;
            // Stage 2: effective stroke alpha
            p2_reg    <= p1_reg;
            sa2_reg   <= div255({x1_reg, 8'd0} + 24'd127);
            da2_reg   <= da1_reg;
            skip2_reg <= skip1_reg;
            er2_reg   <= er1_reg;
            // Stage 3: da*(1-sa) and stroke terms
            p3_reg    <= p2_reg;
            prod3_reg <= {17'd0, da2_reg} * {17'd0, ia};
            for (int i = 0; i < 3; i++)
                ss3_reg[i] <= {17'd0, srgb[i]} * {8'd0, sa2_reg};
            sa3_reg   <= sa2_reg;
            skip3_reg <= skip2_reg;
            er3_reg   <= er2_reg;
            // Stage 4: combined alpha, output alpha, classification
            // (a pass-through pixel keeps its base alpha)
            p4_reg     <= p3_reg;
            ss4_reg    <= ss3_reg;
            t4_reg     <= t;
            oa4_reg    <= oa;
            alpha4_reg <= keep ? p3_reg.base_alpha : (er3_reg ? ea : pa);
            keep4_reg  <= keep;
            er4_reg    <= er3_reg;
            // Stage 5: numerators
            q5_reg.base  <= drgb;
            q5_reg.keep  <= keep4_reg;
            q5_reg.erase <= er4_reg;
            q5_reg.alpha <= alpha4_reg;
            q5_reg.oa    <= oa4_reg;
            for (int i = 0; i < 3; i++)
                q5_reg.num[i] <= {1'b0, ss4_reg[i]} + {1'b0, dt[i]};
        end
    end

endmodule
`default_nettype wire

// File: sv/sooeb_fifo.sv
// Short queue between front and back ends.
// Depends on sooeb_pkg.
`default_nettype none
module sooeb_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sooeb_pkg::qent_t  wdata,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output sooeb_pkg::qent_t       head
);
    import sooeb_pkg::*;

    qent_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [QAW:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    // Pointer and count update
    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop  ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule
`default_nettype wire

// File: sv/sooeb_back.sv
// Back end: pipelined radix-2 divider for the three color channels and result mux.
// Depends on sooeb_pkg.
`default_nettype none
module sooeb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sooeb_pkg::qent_t  head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output sooeb_pkg::res_t        res
);
    import sooeb_pkg::*;

    bst_t              stg_reg  [BSTAGES];
    bst_t              stg_next [BSTAGES];
    logic [BSTAGES-1:0] v_reg;
    logic              out_v_reg;
    res_t              out_reg, out_next;
    logic              en;
    logic [26:0]       dsh;

    assign en        = !out_v_reg || !res_stall;
    assign pop       = !empty && en;
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    // Load from queue, then one quotient bit per stage
    always_comb
    begin
        dsh = '0;
        stg_next[0].base  = head.base;
        stg_next[0].keep  = head.keep;
        stg_next[0].erase = head.erase;
        stg_next[0].alpha = head.alpha;
        stg_next[0].oa    = head.oa;
        stg_next[0].quo   = '0;
        for (int i = 0; i < 3; i++)
            stg_next[0].rem[i] = {1'b0, head.num[i]} + {10'd0, head.oa[17:1]};
        for (int j = 1; j < BSTAGES; j++)
        begin
            stg_next[j] = stg_reg[j-1];
            dsh = {9'd0, stg_reg[j-1].oa} << (QBITS - j);
            for (int i = 0; i < 3; i++)
            begin
                if (stg_reg[j-1].rem[i] >= dsh)
                begin
                    stg_next[j].rem[i] = stg_reg[j-1].rem[i] - dsh;
                    stg_next[j].quo[i][QBITS-j] = 1'b1;
                end
            end
        end
    end

    // Result selection
    always_comb
    begin
        bst_t l;
        l = stg_reg[BSTAGES-1];
        out_next.out_red       = l.base[0];
        out_next.out_green     = l.base[1];
        out_next.out_blue      = l.base[2];
        out_next.out_alpha     = l.alpha;
        out_next.pixel_changed = !l.keep;
        if (!l.keep && !l.erase)
        begin
            out_next.out_red   = clamp8({2'd0, l.quo[0]});
            out_next.out_green = clamp8({2'd0, l.quo[1]});
            out_next.out_blue  = clamp8({2'd0, l.quo[2]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[BSTAGES-2:0], pop};
            out_v_reg <= v_reg[BSTAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < BSTAGES; j++)
                stg_reg[j] <= stg_next[j];
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/stroke_over_or_erase_blend.sv
// Channel   Direction  Handshake          Payload
// pix       in         pix_valid/stall    sooeb_pkg::pix_t
// res       out        res_valid/stall    sooeb_pkg::res_t
// apb       in         psel/penable       opacity, erase mode
// One pixel per clock sustained while results are not stalled; 5 front stages, the queue,
// then 11 back stages (queue read, nine divider steps, result register).
// Reset clears the registers to opacity 256, paint mode, and empties all stages.
// A result stall freezes the back end; the front keeps taking pixels until the queue fills.
// Top level: config registers and the front/queue/back chain. Depends on sooeb_pkg,
// sooeb_front, sooeb_fifo and sooeb_back.
`default_nettype none
module stroke_over_or_erase_blend (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             pix_valid,
    output logic                  pix_stall,
    input  wire sooeb_pkg::pix_t  pix,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output sooeb_pkg::res_t       res
);
    import sooeb_pkg::*;

    logic [8:0] opacity_reg;
    logic       erase_reg;
    logic       wr;
    logic       push, full, pop, empty;
    qent_t      qdata, head;

    // Config registers
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= OPACITY_MAX;
            erase_reg   <= 1'b0;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                REG_OPACITY: opacity_reg <= pwdata[8:0];
                REG_ERASE:   erase_reg   <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_OPACITY: prdata = {23'd0, opacity_reg};
            REG_ERASE:   prdata = {31'd0, erase_reg};
            default:     prdata = '0;
        endcase
    end

    sooeb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .opacity   (opacity_reg),
        .erase     (erase_reg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .push      (push),
        .full      (full),
        .qdata     (qdata)
    );

    sooeb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (qdata),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .head  (head)
    );

    sooeb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
`default_nettype wire
